[design/zmh_pkg.sv]
// Package for the move hash update block: table layout, codes and shared types.
// No dependencies; used by every module of the block except zmh_ram.
package zmh_pkg;

  localparam int TableWords = 850;
  localparam int AddrW      = 10;

  localparam logic [AddrW-1:0] TABLE_LAST  = 10'd849;
  localparam logic [AddrW-1:0] CASTLE_BASE = 10'd768;
  localparam logic [AddrW-1:0] EP_BASE     = 10'd784;
  localparam logic [AddrW-1:0] SIDE_INDEX  = 10'd849;
  localparam logic [AddrW-1:0] TABLE_FULL  = 10'd850;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  localparam logic [2:0] PAWN_CODE = 3'd0;
  localparam logic [2:0] ROOK_CODE = 3'd3;
  localparam logic [2:0] KING_CODE = 3'd5;

  localparam logic [5:0] SHORT_WHITE = 6'd6;
  localparam logic [5:0] SHORT_BLACK = 6'd62;
  localparam logic [5:0] LONG_WHITE  = 6'd2;
  localparam logic [5:0] LONG_BLACK  = 6'd58;
  localparam logic [5:0] RANK_STEP   = 6'd8;

  localparam logic [6:0] EP_NONE = 7'd64;

  // key lookup slots of one move
  localparam logic [3:0] SLOT_FROM   = 4'd0;
  localparam logic [3:0] SLOT_EP_A   = 4'd1;
  localparam logic [3:0] SLOT_EP_B   = 4'd2;
  localparam logic [3:0] SLOT_CS_MOV = 4'd3;
  localparam logic [3:0] SLOT_CS_BRD = 4'd4;
  localparam logic [3:0] SLOT_X      = 4'd5;
  localparam logic [3:0] SLOT_Y      = 4'd6;
  localparam logic [3:0] SLOT_Z      = 4'd7;
  localparam logic [3:0] SLOT_SIDE   = 4'd8;

  typedef struct packed {
    logic       latch;
    logic       load;
    logic       set;
    logic       issue;
    logic [3:0] slot;
  } zmh_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
  } zmh_stat_t;

  // piece key word: (color*6 + pc)*64 + sq
  function automatic logic [AddrW-1:0] piece_addr(input logic color, input logic [2:0] pc,
                                                  input logic [5:0] sq);
    logic [3:0] row;
    row = {1'b0, pc} + (color ? 4'd6 : 4'd0);
    return {row, sq};
  endfunction

endpackage

[design/zmh_ram.sv]
// Generic single-port RAM, one access per cycle, registered read (a write also reads the old word).
// No dependencies.
module zmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 850,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/zmh_ctrl.sv]
// Controller: sequences load, set and the key lookups of a move.
// Depends on zmh_pkg.
module zmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  zmh_pkg::zmh_stat_t stat,
  output zmh_pkg::zmh_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import zmh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] slot, slot_next;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd        = '0;
    cmd.slot   = slot;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        slot_next = SLOT_FROM;
        case (stat.kind)
          KIND_LOAD: begin
            cmd.load   = 1'b1;
            state_next = S_DONE;
          end
          KIND_SET: begin
            cmd.set    = 1'b1;
            state_next = S_DONE;
          end
          KIND_MOVE: state_next = S_RUN;
          default:   state_next = S_DONE;
        endcase
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        slot_next = slot + 4'd1;
        if (slot == SLOT_SIDE) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= SLOT_FROM;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[design/zmh_dpath.sv]
// Datapath: item registers, key table, load pointer, lookup addressing and hash.
// Depends on zmh_pkg and zmh_ram.
module zmh_dpath (
  input  logic               clk,
  input  logic               rst,
  input  zmh_pkg::zmh_cmd_t   cmd,
  output zmh_pkg::zmh_stat_t  stat,
  input  logic [1:0]         kind,
  input  logic [63:0]        key_value,
  input  logic               side,
  input  logic [2:0]         piece,
  input  logic [5:0]         from_square,
  input  logic [5:0]         to_square,
  input  logic [2:0]         captured,
  input  logic [2:0]         promo_piece,
  input  logic [2:0]         move_flags,
  input  logic [6:0]         ep_first,
  input  logic [6:0]         ep_second,
  input  logic [7:0]         castle_pair,
  output logic [63:0]        hash_key,
  output logic               table_ready
);
  import zmh_pkg::*;

  logic [1:0]  kind_q;
  logic [63:0] value_q;
  logic        side_q;
  logic [2:0]  piece_q, cap_q, promo_q, flags_q;
  logic [5:0]  from_q, to_q;
  logic [6:0]  epa_q, epb_q;
  logic [7:0]  cpair_q;

  logic [63:0]      hash;
  logic [AddrW-1:0] ptr;
  logic             rd_valid;

  logic [AddrW-1:0] slot_addr, ram_addr;
  logic             slot_valid, ram_we;
  logic [63:0]      rdata;

  logic             other, castling, short_c, long_c, rights_diff;
  logic [6:0]       epa_c, epb_c;
  logic [5:0]       victim_sq;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q  <= kind;
      value_q <= key_value;
      side_q  <= side;
      piece_q <= piece;
      from_q  <= from_square;
      to_q    <= to_square;
      cap_q   <= captured;
      promo_q <= promo_piece;
      flags_q <= move_flags;
      epa_q   <= ep_first;
      epb_q   <= ep_second;
      cpair_q <= castle_pair;
    end
  end

  assign stat.kind = kind_q;

  assign other       = ~side_q;
  assign epa_c       = epa_q[6] ? EP_NONE : epa_q;
  assign epb_c       = epb_q[6] ? EP_NONE : epb_q;
  assign rights_diff = (cpair_q[7:4] != cpair_q[3:0]);
  assign victim_sq   = side_q ? (to_q + RANK_STEP) : (to_q - RANK_STEP);
  assign castling    = (piece_q == KING_CODE) && flags_q[2];
  assign short_c     = (to_q == (side_q ? SHORT_BLACK : SHORT_WHITE));
  assign long_c      = (to_q == (side_q ? LONG_BLACK : LONG_WHITE));

  always_comb begin
    slot_addr  = SIDE_INDEX;
    slot_valid = 1'b0;
    case (cmd.slot)
      SLOT_FROM: begin
        slot_addr  = piece_addr(side_q, piece_q, from_q);
        slot_valid = (piece_q <= KING_CODE);
      end
      SLOT_EP_A: begin
        slot_addr  = EP_BASE + {3'b000, epa_c};
        slot_valid = 1'b1;
      end
      SLOT_EP_B: begin
        slot_addr  = EP_BASE + {3'b000, epb_c};
        slot_valid = 1'b1;
      end
      SLOT_CS_MOV: begin
        slot_addr  = CASTLE_BASE + {6'b000000, cpair_q[3:0]};
        slot_valid = rights_diff;
      end
      SLOT_CS_BRD: begin
        slot_addr  = CASTLE_BASE + {6'b000000, cpair_q[7:4]};
        slot_valid = rights_diff;
      end
      SLOT_X: begin
        if (piece_q == PAWN_CODE) begin
          slot_addr  = piece_addr(other, PAWN_CODE, victim_sq);
          slot_valid = flags_q[0];
        end else if (castling) begin
          slot_addr  = piece_addr(side_q, KING_CODE, to_q);
          slot_valid = short_c | long_c;
        end else begin
          slot_addr  = piece_addr(side_q, piece_q, to_q);
          slot_valid = (piece_q <= KING_CODE);
        end
      end
      SLOT_Y: begin
        if (piece_q == PAWN_CODE) begin
          slot_addr  = piece_addr(side_q, flags_q[1] ? promo_q : PAWN_CODE, to_q);
          slot_valid = !flags_q[1] || (promo_q <= KING_CODE);
        end else if (castling) begin
          slot_addr  = piece_addr(side_q, ROOK_CODE, to_q + 6'd1);
          slot_valid = short_c | long_c;
        end else begin
          slot_addr  = piece_addr(other, cap_q, to_q);
          slot_valid = (cap_q <= KING_CODE);
        end
      end
      SLOT_Z: begin
        if (piece_q == PAWN_CODE) begin
          slot_addr  = piece_addr(other, cap_q, to_q);
          slot_valid = (cap_q <= KING_CODE);
        end else if (castling) begin
          slot_addr  = piece_addr(side_q, ROOK_CODE, short_c ? (to_q - 6'd1) : (to_q - 6'd2));
          slot_valid = short_c | long_c;
        end
      end
      SLOT_SIDE: begin
        slot_addr  = SIDE_INDEX;
        slot_valid = 1'b1;
      end
      default: begin
        slot_addr  = SIDE_INDEX;
        slot_valid = 1'b0;
      end
    endcase
  end

  assign ram_we   = cmd.load && (ptr <= TABLE_LAST);
  assign ram_addr = cmd.load ? ptr : slot_addr;

  zmh_ram #(
    .WIDTH(64),
    .DEPTH(TableWords)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(value_q),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      hash     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue && slot_valid;
      if (ram_we) begin
        ptr <= ptr + 10'd1;
      end
      if (cmd.set) begin
        hash <= value_q;
      end else if (rd_valid) begin
        hash <= hash ^ rdata;
      end
    end
  end

  assign hash_key    = hash;
  assign table_ready = (ptr == TABLE_FULL);

endmodule

[design/zobrist_move_hash_update.sv]
// Top level of the incremental position hash block: controller plus datapath.
// Depends on zmh_pkg, zmh_ctrl, zmh_dpath (and zmh_ram through the datapath).
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+---------------------------
//   item in | kind key_value side piece ... castle_pair | start high while busy low
//   result  | hash_key table_ready                     | done strobe, one cycle
//
// Load, set and ignored kinds go from decode straight to done; a move runs nine
// key lookups (source, two en passant, two castling, three placement, side)
// from the single table port, one per cycle, after decode, then drain and done.
// busy is low again the cycle after done. Reset clears the hash and load pointer.
// The result strobe is not held off; the next item may be issued once busy drops.
module zobrist_move_hash_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] key_value,
  input  logic        side,
  input  logic [2:0]  piece,
  input  logic [5:0]  from_square,
  input  logic [5:0]  to_square,
  input  logic [2:0]  captured,
  input  logic [2:0]  promo_piece,
  input  logic [2:0]  move_flags,
  input  logic [6:0]  ep_first,
  input  logic [6:0]  ep_second,
  input  logic [7:0]  castle_pair,
  output logic        done,
  output logic [63:0] hash_key,
  output logic        table_ready
);
  import zmh_pkg::*;

  zmh_cmd_t  cmd;
  zmh_stat_t stat;

  zmh_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  zmh_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .key_value  (key_value),
    .side       (side),
    .piece      (piece),
    .from_square(from_square),
    .to_square  (to_square),
    .captured   (captured),
    .promo_piece(promo_piece),
    .move_flags (move_flags),
    .ep_first   (ep_first),
    .ep_second  (ep_second),
    .castle_pair(castle_pair),
    .hash_key   (hash_key),
    .table_ready(table_ready)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not make the block busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    table_ready |=> table_ready)
    else $error("table_ready dropped without reset");

  a_hash_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> $stable(hash_key))
    else $error("hash changed while idle");

endmodule
